### hdl/kabt_pkg.sv
// shared constants, codes and control structs for the keyed allocation balance table
package kabt_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_CHARS = 8;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam int KEY_W = 64;
    localparam int AMT_W = 48;
    localparam int VAL_W = 64;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 320;

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic load;
        logic lookup;
        logic sum;
        logic diff;
        logic commit;
    } kabt_cmd_t;

    typedef struct packed {
        logic out_busy;
    } kabt_stat_t;

endpackage

### hdl/kabt_ctrl.sv
// sequencer for the lookup, update and result steps of one transaction
module kabt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  kabt_pkg::kabt_stat_t stat,
    output kabt_pkg::kabt_cmd_t  cmd
);
    import kabt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_DIFF   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/kabt_dpath.sv
// key table, counter storage, update arithmetic and output register
module kabt_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kabt_pkg::kabt_cmd_t               cmd,
    output kabt_pkg::kabt_stat_t              stat,
    input  logic [kabt_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [kabt_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kabt_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [kabt_pkg::ST_W-1:0]         m_tuser
);
    import kabt_pkg::*;

    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             alive;
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            // name ends at the first zero byte or at the character limit
            if (i >= KEY_CHARS || k[8*i +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                r[8*i +: 8] = k[8*i +: 8];
            end
        end
        return r;
    endfunction

    // captured transaction
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AMT_W-1:0] amt_reg;

    // table storage
    logic [KEY_W-1:0] key_tbl_reg   [ENTRIES];
    logic [VAL_W-1:0] alloc_tbl_reg [ENTRIES];
    logic [VAL_W-1:0] free_tbl_reg  [ENTRIES];
    logic [VAL_W-1:0] peak_tbl_reg  [ENTRIES];
    logic [VAL_W-1:0] evt_tbl_reg   [ENTRIES];
    logic [CNT_W-1:0] used_reg;

    // lookup results
    logic [IDX_W-1:0] slot_reg;
    logic             new_reg;
    logic             ok_reg;
    logic [ST_W-1:0]  status_reg;

    // working values
    logic [VAL_W-1:0] a_reg;
    logic [VAL_W-1:0] f_reg;
    logic [VAL_W-1:0] pk_reg;
    logic [VAL_W-1:0] ev_reg;
    logic [VAL_W-1:0] bal_reg;
    logic             pos_reg;

    // output register
    logic             m_tvalid_reg;
    logic [ST_W-1:0]  out_st_reg;
    logic [VAL_W-1:0] out_bal_reg;
    logic [VAL_W-1:0] out_a_reg;
    logic [VAL_W-1:0] out_f_reg;
    logic [VAL_W-1:0] out_pk_reg;
    logic [VAL_W-1:0] out_ev_reg;

    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0]   match_idx;
    logic               hit;
    logic               full;
    logic               is_rec;
    logic               is_qry;
    logic               create;
    logic [IDX_W-1:0]   free_idx;

    logic [VAL_W-1:0]   rd_a;
    logic [VAL_W-1:0]   rd_f;
    logic [VAL_W-1:0]   rd_pk;
    logic [VAL_W-1:0]   rd_ev;
    logic [VAL_W-1:0]   amt_sext;
    logic [VAL_W-1:0]   a_next;
    logic [VAL_W-1:0]   f_next;
    logic [VAL_W-1:0]   ev_next;
    logic [VAL_W:0]     diff_wide;
    logic [VAL_W-1:0]   clamp;
    logic [VAL_W-1:0]   pk_next;
    logic               rec_ok;

    always_comb
    begin
        match     = '0;
        match_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (CNT_W'(i) < used_reg) && (key_tbl_reg[i] == key_reg);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                match_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |match;
    assign full     = (used_reg == CNT_W'(ENTRIES));
    assign is_rec   = (op_reg == OP_RECORD);
    assign is_qry   = (op_reg == OP_QUERY);
    assign create   = is_rec && !hit && !full;
    assign free_idx = used_reg[IDX_W-1:0];

    // a freshly created entry reads as zero
    assign rd_a  = new_reg ? '0 : alloc_tbl_reg[slot_reg];
    assign rd_f  = new_reg ? '0 : free_tbl_reg[slot_reg];
    assign rd_pk = new_reg ? '0 : peak_tbl_reg[slot_reg];
    assign rd_ev = new_reg ? '0 : evt_tbl_reg[slot_reg];

    assign rec_ok   = is_rec && ok_reg;
    assign amt_sext = {{(VAL_W-AMT_W){amt_reg[AMT_W-1]}}, amt_reg};

    always_comb
    begin
        a_next  = rd_a;
        f_next  = rd_f;
        ev_next = rd_ev;
        if (rec_ok)
        begin
            ev_next = rd_ev + VAL_W'(1);
            // subtracting the sign-extended amount adds its magnitude
            if (amt_reg[AMT_W-1])
            begin
                f_next = rd_f - amt_sext;
            end
            else
            begin
                a_next = rd_a + amt_sext;
            end
        end
    end

    assign diff_wide = {1'b0, a_reg} - {1'b0, f_reg};
    assign clamp     = pos_reg ? bal_reg : '0;
    assign pk_next   = (rec_ok && (clamp > pk_reg)) ? clamp : pk_reg;

    // payload and storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= s_tuser;
            key_reg <= norm_key(s_tdata[KEY_W-1:0]);
            amt_reg <= s_tdata[KEY_W +: AMT_W];
        end

        if (cmd.lookup)
        begin
            slot_reg <= hit ? match_idx : free_idx;
            new_reg  <= create;
            ok_reg   <= (is_rec && (hit || !full)) || (is_qry && hit);
            if (is_rec && !hit && full)
            begin
                status_reg <= ST_FULL;
            end
            else if (is_qry && !hit)
            begin
                status_reg <= ST_NOT_FOUND;
            end
            else
            begin
                status_reg <= ST_OK;
            end
            if (create)
            begin
                key_tbl_reg[free_idx] <= key_reg;
            end
            if (op_reg == OP_CLEAR)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    alloc_tbl_reg[i] <= '0;
                    free_tbl_reg[i]  <= '0;
                    peak_tbl_reg[i]  <= '0;
                    evt_tbl_reg[i]   <= '0;
                end
            end
        end

        if (cmd.sum)
        begin
            if (ok_reg)
            begin
                a_reg  <= a_next;
                f_reg  <= f_next;
                pk_reg <= rd_pk;
                ev_reg <= ev_next;
            end
            else
            begin
                a_reg  <= '0;
                f_reg  <= '0;
                pk_reg <= '0;
                ev_reg <= '0;
            end
        end

        if (cmd.diff)
        begin
            bal_reg <= diff_wide[VAL_W-1:0];
            pos_reg <= !diff_wide[VAL_W] && (diff_wide[VAL_W-1:0] != '0);
        end

        if (cmd.commit)
        begin
            if (rec_ok)
            begin
                alloc_tbl_reg[slot_reg] <= a_reg;
                free_tbl_reg[slot_reg]  <= f_reg;
                peak_tbl_reg[slot_reg]  <= pk_next;
                evt_tbl_reg[slot_reg]   <= ev_reg;
            end
            out_st_reg  <= status_reg;
            out_bal_reg <= bal_reg;
            out_a_reg   <= a_reg;
            out_f_reg   <= f_reg;
            out_pk_reg  <= pk_next;
            out_ev_reg  <= ev_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup && create)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (cmd.commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tuser       = out_st_reg;
    assign m_tdata       = {out_ev_reg, out_pk_reg, out_f_reg, out_a_reg, out_bal_reg};

endmodule

### hdl/keyed_alloc_balance_table_top.sv
// top level of the keyed allocation balance table
//
// input stream: s_tuser carries the opcode (record, query, clear), s_tdata the key
// and, for record, a signed amount. one result transaction leaves on the output
// stream for every input transaction: m_tuser carries the status, m_tdata the
// balance, allocated total, freed total, peak and event count of the entry.
// the block handles one transaction at a time. it is taken in the idle cycle,
// then goes through key lookup (all entries compared at once), counter update,
// balance subtraction and the write-back of the entry, which also loads the
// output register, which holds a result while the receiver stalls; a stall
// only blocks the write-back step of the following transaction.
// after reset the table holds no names and both channels are idle; no
// clearing pass is needed since only entries below the fill count are read.
module keyed_alloc_balance_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kabt_pkg::S_DATA_W-1:0] s_tdata,   // key[63:0], amount[111:64]
    input  logic [kabt_pkg::OP_W-1:0]     s_tuser,   // opcode[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // balance[63:0], allocated_total[127:64], freed_total[191:128],
    // peak[255:192], events[319:256]
    output logic [kabt_pkg::M_DATA_W-1:0] m_tdata,
    output logic [kabt_pkg::ST_W-1:0]     m_tuser    // status[1:0]
);
    import kabt_pkg::*;

    kabt_cmd_t  cmd;
    kabt_stat_t stat;

    kabt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kabt_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_NOT_FOUND))
        else $error("unused status code on output");

    // failed record or query returns all counters zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NOT_FOUND)) |-> (m_tdata == '0))
        else $error("non-zero counters on a failed transaction");

    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:0] == m_tdata[127:64] - m_tdata[191:128]))
        else $error("balance differs from allocated minus freed");

endmodule

### test/tb_top.sv
// testbench for the keyed allocation balance table: directed and random traffic against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kabt_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam logic [AMT_W-1:0] AMT_MAX      = {1'b0, {(AMT_W-1){1'b1}}};
    localparam logic [AMT_W-1:0] AMT_MIN      = {1'b1, {(AMT_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_ONES     = {KEY_W{1'b1}};
    localparam int               RANDOM_ITEMS = 1000;
    localparam int               CALM_ITEMS   = 200;
    localparam int               DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] balance;
        logic [VAL_W-1:0] alloc;
        logic [VAL_W-1:0] freed;
        logic [VAL_W-1:0] peak;
        logic [VAL_W-1:0] events;
    } ledger_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;

    // predicted table contents
    logic [KEY_W-1:0] name_tab   [ENTRIES];
    logic [VAL_W-1:0] alloc_tab  [ENTRIES];
    logic [VAL_W-1:0] freed_tab  [ENTRIES];
    logic [VAL_W-1:0] peak_tab   [ENTRIES];
    logic [VAL_W-1:0] events_tab [ENTRIES];
    int               names_used = 0;

    ledger_result_t pending_results[$];
    ledger_result_t got_result;
    ledger_result_t want_result;
    int             mismatches = 0;
    bit             idle_on    = 1'b1;
    int             stall_left = 0;

    keyed_alloc_balance_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // name ends at the first zero byte or after KEY_CHARS characters
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        bit               ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] nk);
        int slot;
        slot = -1;
        for (int i = 0; i < names_used; i++)
            if (slot < 0 && name_tab[i] == nk)
                slot = i;
        return slot;
    endfunction

    function automatic ledger_result_t apply_ledger_op(input logic [OP_W-1:0]  op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [AMT_W-1:0] amt);
        ledger_result_t          res;
        int                      slot;
        logic [KEY_W-1:0]        nk;
        logic [VAL_W-1:0]        bal;
        logic signed [VAL_W-1:0] wide_amt;
        res        = '0;
        res.status = ST_OK;
        nk         = trim_key(key);
        slot       = -1;
        wide_amt   = VAL_W'($signed(amt));
        case (op)
            OP_RECORD:
            begin
                slot = find_slot(nk);
                if (slot < 0 && names_used == ENTRIES)
                    res.status = ST_FULL;
                else
                begin
                    if (slot < 0)
                    begin
                        slot             = names_used;
                        names_used       = names_used + 1;
                        name_tab[slot]   = nk;
                        alloc_tab[slot]  = '0;
                        freed_tab[slot]  = '0;
                        peak_tab[slot]   = '0;
                        events_tab[slot] = '0;
                    end
                    if (amt[AMT_W-1])
                        freed_tab[slot] = freed_tab[slot] + VAL_W'(-wide_amt);
                    else
                        alloc_tab[slot] = alloc_tab[slot] + VAL_W'(amt);
                    events_tab[slot] = events_tab[slot] + VAL_W'(1);
                    // peak follows the balance clamped at zero
                    bal = (alloc_tab[slot] > freed_tab[slot]) ?
                          alloc_tab[slot] - freed_tab[slot] : '0;
                    if (bal > peak_tab[slot])
                        peak_tab[slot] = bal;
                end
            end
            OP_QUERY:
            begin
                slot = find_slot(nk);
                if (slot < 0)
                    res.status = ST_NOT_FOUND;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < names_used; i++)
                begin
                    alloc_tab[i]  = '0;
                    freed_tab[i]  = '0;
                    peak_tab[i]   = '0;
                    events_tab[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (slot >= 0)
        begin
            res.balance = alloc_tab[slot] - freed_tab[slot];
            res.alloc   = alloc_tab[slot];
            res.freed   = freed_tab[slot];
            res.peak    = peak_tab[slot];
            res.events  = events_tab[slot];
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] random_name();
        logic [KEY_W-1:0] nm;
        int               len;
        nm  = '0;
        len = $urandom_range(0, KEY_CHARS);
        for (int i = 0; i < len; i++)
            nm[8*i +: 8] = 8'($urandom_range(1, 255));
        return nm;
    endfunction

    // same name, sometimes with random bytes past the terminating zero
    function automatic logic [KEY_W-1:0] alias_key(input logic [KEY_W-1:0] nk);
        int               len;
        logic [KEY_W-1:0] junk;
        len = 0;
        for (int i = 0; i < 8; i++)
            if (nk[8*i +: 8] != 8'd0 && len == i)
                len = i + 1;
        if (len >= 7 || $urandom_range(0, 1) == 0)
            return nk;
        junk = {$urandom, $urandom};
        return nk | (junk << (8 * (len + 1)));
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        logic [AMT_W-1:0] a;
        case ($urandom_range(0, 7))
            0:       a = '0;
            1:       a = AMT_W'($urandom_range(1, 1000));
            2:       a = -AMT_W'($urandom_range(1, 1000));
            3, 4:    a = AMT_W'({$urandom, $urandom});
            5:       a = AMT_MAX;
            6:       a = AMT_MIN;
            default: a = AMT_W'($urandom_range(0, 1 << 21)) - AMT_W'(1 << 20);
        endcase
        return a;
    endfunction

    task automatic send_item(input logic [OP_W-1:0]  op,
                             input logic [KEY_W-1:0] key,
                             input logic [AMT_W-1:0] amt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {amt, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_ledger_op(op, key, amt));
    endtask

    task automatic test_directed_basics();
        send_item(OP_QUERY, '0, '0);                          // empty table
        send_item(OP_RECORD, '0, '0);                         // empty name, zero amount
        send_item(OP_RECORD, KEY_ONES, AMT_MAX);
        send_item(OP_RECORD, KEY_ONES, AMT_MIN);              // balance goes negative
        send_item(OP_RECORD, KEY_ONES, AMT_W'(5));
        send_item(OP_RECORD, 64'h00FF_0000_0000_0041, AMT_W'(100));
        send_item(OP_RECORD, 64'h0000_0000_0000_0041, -AMT_W'(300));
        send_item(OP_QUERY, 64'hDEAD_BEEF_0000_0041, '0);
        send_item(OP_QUERY, 64'h0000_0000_0000_4100, '0);     // empty name after zero byte
        send_item(OP_UNUSED, KEY_ONES, AMT_MIN);
        send_item(OP_CLEAR, KEY_ONES, AMT_MAX);
        send_item(OP_QUERY, KEY_ONES, '0);
        send_item(OP_RECORD, KEY_ONES, AMT_W'(7));
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] nm;
        while (names_used < ENTRIES)
            send_item(OP_RECORD, random_name(), pick_amount());
        do
            nm = random_name();
        while (find_slot(nm) >= 0);
        send_item(OP_RECORD, nm, AMT_W'(1000));
        send_item(OP_QUERY, nm, '0);
        send_item(OP_RECORD, alias_key(name_tab[ENTRIES-1]), AMT_W'(5));
    endtask

    task automatic test_random_traffic();
        int               done;
        int               pick;
        logic [KEY_W-1:0] known;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            idle_on = (done < RANDOM_ITEMS - CALM_ITEMS);
            pick    = $urandom_range(0, 99);
            known   = alias_key(name_tab[$urandom_range(0, names_used - 1)]);
            if (pick < 50)
                send_item(OP_RECORD, known, pick_amount());
            else if (pick < 78)
                send_item(OP_QUERY, known, AMT_W'({$urandom, $urandom}));
            else if (pick < 86)
                send_item(OP_RECORD, {$urandom, $urandom}, pick_amount());
            else if (pick < 94)
                send_item(OP_QUERY, {$urandom, $urandom}, '0);
            else if (pick < 97)
                send_item(OP_CLEAR, {$urandom, $urandom}, AMT_W'({$urandom, $urandom}));
            else
                send_item(OP_UNUSED, {$urandom, $urandom}, AMT_W'({$urandom, $urandom}));
            if (pick < 97)
                done++;
        end
    endtask

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 9);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result.status  = m_tuser;
            got_result.balance = m_tdata[0*VAL_W +: VAL_W];
            got_result.alloc   = m_tdata[1*VAL_W +: VAL_W];
            got_result.freed   = m_tdata[2*VAL_W +: VAL_W];
            got_result.peak    = m_tdata[3*VAL_W +: VAL_W];
            got_result.events  = m_tdata[4*VAL_W +: VAL_W];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result transaction status=%0d", $realtime,
                             got_result.status);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  status  exp %0d got %0d", want_result.status,
                                 got_result.status);
                        $display("  balance exp %h got %h", want_result.balance,
                                 got_result.balance);
                        $display("  alloc   exp %h got %h", want_result.alloc,
                                 got_result.alloc);
                        $display("  freed   exp %h got %h", want_result.freed,
                                 got_result.freed);
                        $display("  peak    exp %h got %h", want_result.peak,
                                 got_result.peak);
                        $display("  events  exp %h got %h", want_result.events,
                                 got_result.events);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_table_full();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
